FILE: sv/sddmm_pkg.sv
`default_nettype none

package sddmm_pkg;

  // default store geometry
  localparam int MAX_ROWS_DEF     = 256;
  localparam int MAX_COLS_DEF     = 256;
  localparam int MAX_FEATURES_DEF = 64;

  // feature index width that covers the largest supported row length
  localparam int FEAT_IDX_W = 10;

  // configuration register
  localparam int         FC_W     = 7;
  localparam logic [6:0] FC_RESET = 7'd64;

  // read-to-accumulate latency of the multiply-accumulate pipe
  localparam int MAC_LATENCY = 2;

  // input commands
  typedef enum logic [1:0] {
    CMD_WRITE_A = 2'd0,
    CMD_WRITE_B = 2'd1,
    CMD_SAMPLE  = 2'd2
  } cmd_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_DRAIN,
    ST_ABS,
    ST_SCALE,
    ST_FINISH,
    ST_RESULT
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic                  load_a;
    logic                  load_b;
    logic                  capture;
    logic                  rd_en;
    logic [FEAT_IDX_W-1:0] rd_feat;
    logic                  abs_load;
    logic                  scale_en;
    logic                  out_load;
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic sample_in_range;
  } dp_status_t;

  // signed accumulator width: products reach 2^62 in magnitude
  function automatic int acc_width(input int max_features);
    return 64 + $clog2(max_features + 1);
  endfunction

  // 32-bit chunks of the accumulator magnitude
  function automatic int chunk_count(input int max_features);
    return (acc_width(max_features) + 31) / 32;
  endfunction

endpackage

`default_nettype wire

FILE: sv/sddmm_ctrl.sv
`default_nettype none

module sddmm_ctrl #(
  parameter int MAX_FEATURES = sddmm_pkg::MAX_FEATURES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  input  wire logic [1:0]                 command,
  output logic                            in_stall,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [sddmm_pkg::FC_W-1:0] feature_count,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  input  wire sddmm_pkg::dp_status_t      status,
  output sddmm_pkg::ctrl_cmd_t            cmd
);

  localparam int N_W        = $clog2(MAX_FEATURES + 1);
  localparam int NCH        = sddmm_pkg::chunk_count(MAX_FEATURES);
  localparam int CHUNK_W    = $clog2(NCH);
  localparam int CNT_W      = (N_W > CHUNK_W) ? N_W : CHUNK_W;

  sddmm_pkg::state_t state;
  sddmm_pkg::state_t state_next;

  logic [CNT_W-1:0]          cnt;
  logic [N_W-1:0]            n_reg;
  logic [N_W-1:0]            n_eff;
  logic [sddmm_pkg::FC_W-1:0] fc;
  logic                      accept;
  logic                      is_sample;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && (state == sddmm_pkg::ST_IDLE);
  assign is_sample = (command == sddmm_pkg::CMD_SAMPLE);

  // terms in this sample: clamped count, none for rows out of range
  always_comb begin
    if (!status.sample_in_range) begin
      n_eff = '0;
    end else if (32'(fc) > 32'(MAX_FEATURES)) begin
      n_eff = N_W'(MAX_FEATURES);
    end else begin
      n_eff = N_W'(fc);
    end
  end

  // feature count register
  always_ff @(posedge clk) begin
    if (rst) begin
      fc <= sddmm_pkg::FC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      fc <= feature_count;
    end
  end

  // state, step counter, term count
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sddmm_pkg::ST_IDLE;
      cnt   <= '0;
      n_reg <= '0;
    end else begin
      state <= state_next;
      if (state != state_next) begin
        cnt <= '0;
      end else begin
        cnt <= cnt + CNT_W'(1);
      end
      if (accept && is_sample) begin
        n_reg <= n_eff;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      sddmm_pkg::ST_IDLE: begin
        if (accept && is_sample) begin
          state_next = (n_eff != '0) ? sddmm_pkg::ST_FETCH : sddmm_pkg::ST_DRAIN;
        end
      end
      sddmm_pkg::ST_FETCH: begin
        if (32'(cnt) + 32'd1 == 32'(n_reg)) begin
          state_next = sddmm_pkg::ST_DRAIN;
        end
      end
      sddmm_pkg::ST_DRAIN: begin
        if (32'(cnt) == 32'(sddmm_pkg::MAC_LATENCY - 1)) begin
          state_next = sddmm_pkg::ST_ABS;
        end
      end
      sddmm_pkg::ST_ABS: begin
        state_next = sddmm_pkg::ST_SCALE;
      end
      sddmm_pkg::ST_SCALE: begin
        if (32'(cnt) == 32'(NCH - 1)) begin
          state_next = sddmm_pkg::ST_FINISH;
        end
      end
      sddmm_pkg::ST_FINISH: begin
        state_next = sddmm_pkg::ST_RESULT;
      end
      sddmm_pkg::ST_RESULT: begin
        if (!out_valid || !out_stall) begin
          state_next = sddmm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sddmm_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath commands and input stall
  always_comb begin
    in_stall     = (state != sddmm_pkg::ST_IDLE);
    cmd          = '0;
    cmd.load_a   = accept && (command == sddmm_pkg::CMD_WRITE_A);
    cmd.load_b   = accept && (command == sddmm_pkg::CMD_WRITE_B);
    cmd.capture  = accept && is_sample;
    cmd.rd_en    = (state == sddmm_pkg::ST_FETCH);
    cmd.rd_feat  = sddmm_pkg::FEAT_IDX_W'(cnt);
    cmd.abs_load = (state == sddmm_pkg::ST_ABS);
    cmd.scale_en = (state == sddmm_pkg::ST_SCALE);
    cmd.out_load = (state == sddmm_pkg::ST_RESULT) && (!out_valid || !out_stall);
  end

  // output beat register flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // an accepted sample always starts a computation
  a_sample_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && is_sample) |=> (state != sddmm_pkg::ST_IDLE))
    else $error("sample beat did not start a computation");

  // fetch only runs over a nonempty row and stays inside it
  a_fetch_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == sddmm_pkg::ST_FETCH) |-> (n_reg != '0 && 32'(cnt) < 32'(n_reg)))
    else $error("fetch counter outside the term count");

  // store writes never collide with dot product reads
  a_no_write_during_read: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_a || cmd.load_b) |-> !cmd.rd_en)
    else $error("store write during fetch");

  // a finished result waits while the output register is held
  a_result_waits: assert property (@(posedge clk) disable iff (rst)
    (state == sddmm_pkg::ST_RESULT && out_valid && out_stall)
      |=> (state == sddmm_pkg::ST_RESULT))
    else $error("result dropped while output stalled");

endmodule

`default_nettype wire

FILE: sv/sddmm_dp.sv
`default_nettype none

module sddmm_dp #(
  parameter int MAX_ROWS     = sddmm_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS     = sddmm_pkg::MAX_COLS_DEF,
  parameter int MAX_FEATURES = sddmm_pkg::MAX_FEATURES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [7:0]            row_index,
  input  wire logic [7:0]            col_index,
  input  wire logic [5:0]            feature_index,
  input  wire logic signed [31:0]    data_value,
  input  wire logic                  last_flag,
  input  wire sddmm_pkg::ctrl_cmd_t  cmd,
  output sddmm_pkg::dp_status_t      status,
  output logic signed [31:0]         scaled_value,
  output logic                       last_out
);

  localparam int FEAT_W  = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int A_DEPTH = MAX_ROWS * MAX_FEATURES;
  localparam int B_DEPTH = MAX_COLS * MAX_FEATURES;
  localparam int A_AW    = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
  localparam int B_AW    = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;
  localparam int ACC_W   = sddmm_pkg::acc_width(MAX_FEATURES);
  localparam int NCH     = sddmm_pkg::chunk_count(MAX_FEATURES);
  localparam int MAG_W   = NCH * 32;

  // scale step phases
  localparam logic [1:0] PH_ROUND = 2'd0;
  localparam logic [1:0] PH_LOW   = 2'd1;
  localparam logic [1:0] PH_HIGH  = 2'd2;

  localparam logic [32:0] ROUND_HALF = 33'h0_8000_0000;
  localparam logic [31:0] POS_LIMIT  = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_LIMIT  = 32'h8000_0000;

  logic [31:0] a_mem [A_DEPTH];
  logic [31:0] b_mem [B_DEPTH];

  logic              a_row_ok;
  logic              b_row_ok;
  logic              feat_ok;
  logic [A_AW-1:0]   a_waddr;
  logic [B_AW-1:0]   b_waddr;
  logic [A_AW-1:0]   a_raddr;
  logic [B_AW-1:0]   b_raddr;
  logic [FEAT_W-1:0] rd_feat;

  logic [7:0]  arow;
  logic [7:0]  brow;
  logic [31:0] vmag;
  logic        vneg;
  logic        last_hold;

  logic [31:0]              a_rd;
  logic [31:0]              b_rd;
  logic                     rd_valid;
  logic signed [63:0]       prod;
  logic                     prod_valid;
  logic signed [ACC_W-1:0]  acc;
  logic [ACC_W-1:0]         acc_mag;

  logic [MAG_W-1:0] mag_sh;
  logic             res_neg;
  logic [63:0]      pprod;
  logic             sc_v;
  logic [1:0]       phase;
  logic [32:0]      carry;
  logic [32:0]      carry_in;
  logic [64:0]      t_sum;
  logic [31:0]      qlow;
  logic             ovf;

  logic [31:0] limit;
  logic [31:0] qsat;
  logic [31:0] res;

  // range checks and store addresses
  assign a_row_ok = 32'(row_index) < 32'(MAX_ROWS);
  assign b_row_ok = 32'(col_index) < 32'(MAX_COLS);
  assign feat_ok  = 32'(feature_index) < 32'(MAX_FEATURES);
  assign status.sample_in_range = a_row_ok && b_row_ok;

  assign rd_feat = cmd.rd_feat[FEAT_W-1:0];
  assign a_waddr = A_AW'(32'(row_index) * 32'(MAX_FEATURES) + 32'(feature_index));
  assign b_waddr = B_AW'(32'(col_index) * 32'(MAX_FEATURES) + 32'(feature_index));
  assign a_raddr = A_AW'(32'(arow) * 32'(MAX_FEATURES) + 32'(rd_feat));
  assign b_raddr = B_AW'(32'(brow) * 32'(MAX_FEATURES) + 32'(rd_feat));

  // factor store A
  always_ff @(posedge clk) begin
    if (cmd.load_a && a_row_ok && feat_ok) begin
      a_mem[a_waddr] <= data_value;
    end
    if (cmd.rd_en) begin
      a_rd <= a_mem[a_raddr];
    end
  end

  // factor store B
  always_ff @(posedge clk) begin
    if (cmd.load_b && b_row_ok && feat_ok) begin
      b_mem[b_waddr] <= data_value;
    end
    if (cmd.rd_en) begin
      b_rd <= b_mem[b_raddr];
    end
  end

  // sample operands
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      arow      <= row_index;
      brow      <= col_index;
      vneg      <= data_value[31];
      vmag      <= data_value[31] ? (~data_value + 32'd1) : data_value;
      last_hold <= last_flag;
    end
  end

  // pipe valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid   <= 1'b0;
      prod_valid <= 1'b0;
      sc_v       <= 1'b0;
    end else begin
      rd_valid   <= cmd.rd_en;
      prod_valid <= rd_valid;
      sc_v       <= cmd.scale_en;
    end
  end

  // multiply-accumulate
  always_ff @(posedge clk) begin
    prod <= $signed(a_rd) * $signed(b_rd);
    if (cmd.capture) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= acc + {{(ACC_W - 64){prod[63]}}, prod};
    end
  end

  // sign and magnitude of the dot product
  assign acc_mag = acc[ACC_W-1] ? (~acc + ACC_W'(1)) : acc;

  // scale step 1: one 32x32 partial product per chunk
  always_ff @(posedge clk) begin
    if (cmd.abs_load) begin
      mag_sh  <= MAG_W'(acc_mag);
      res_neg <= acc[ACC_W-1] ^ vneg;
    end else if (cmd.scale_en) begin
      pprod  <= 64'(mag_sh[31:0]) * 64'(vmag);
      mag_sh <= mag_sh >> 32;
    end
  end

  // scale step 2: add carry, round on the low chunk, flag overflow above
  assign carry_in = (phase == PH_ROUND) ? ROUND_HALF : carry;
  assign t_sum    = 65'(pprod) + 65'(carry_in);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_ROUND;
    end else if (cmd.abs_load) begin
      phase <= PH_ROUND;
    end else if (sc_v && phase != PH_HIGH) begin
      phase <= phase + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.abs_load) begin
      ovf <= 1'b0;
    end else if (sc_v) begin
      carry <= t_sum[64:32];
      case (phase)
        PH_ROUND: begin
        end
        PH_LOW: begin
          qlow <= t_sum[31:0];
          ovf  <= (t_sum[64:32] != '0);
        end
        default: begin
          ovf <= ovf || (t_sum != '0);
        end
      endcase
    end
  end

  // saturate and restore sign
  assign limit = res_neg ? NEG_LIMIT : POS_LIMIT;
  assign qsat  = (ovf || qlow > limit) ? limit : qlow;
  assign res   = res_neg ? (~qsat + 32'd1) : qsat;

  // output beat register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      scaled_value <= res;
      last_out     <= last_hold;
    end
  end

endmodule

`default_nettype wire

FILE: sv/sampled_dense_dense_matmul_core.sv
`default_nettype none

// channel   direction  handshake               payload
// input     in         in_valid / in_stall     command, row_index, col_index,
//                                              feature_index, data_value, last_flag
// output    out        out_valid / out_stall   scaled_value, last_out
// config    in         cfg_valid / cfg_ready   feature_count
//
// load beats (write A, write B, unused code) are taken one per cycle, back to back
// a sample reads n feature terms, n = min(feature_count, MAX_FEATURES), or 0 for
// rows out of range; one read port per store feeds one 32x32 multiply-accumulate
// the scale stage adds three 32x32 partial-product steps for the final product
// reset (rst, synchronous) returns to idle with feature_count = 64; stores keep data
// a result waits in the output register under out_stall; idle still takes new beats

module sampled_dense_dense_matmul_core #(
  parameter int MAX_ROWS     = sddmm_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS     = sddmm_pkg::MAX_COLS_DEF,
  parameter int MAX_FEATURES = sddmm_pkg::MAX_FEATURES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [1:0]                 command,
  input  wire logic [7:0]                 row_index,
  input  wire logic [7:0]                 col_index,
  input  wire logic [5:0]                 feature_index,
  input  wire logic signed [31:0]         data_value,
  input  wire logic                       last_flag,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic signed [31:0]              scaled_value,
  output logic                            last_out,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [sddmm_pkg::FC_W-1:0] feature_count
);

  sddmm_pkg::ctrl_cmd_t  cmd;
  sddmm_pkg::dp_status_t status;

  // sequencer
  sddmm_ctrl #(
    .MAX_FEATURES (MAX_FEATURES)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .command       (command),
    .in_stall      (in_stall),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .feature_count (feature_count),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .cmd           (cmd)
  );

  // stores and arithmetic
  sddmm_dp #(
    .MAX_ROWS     (MAX_ROWS),
    .MAX_COLS     (MAX_COLS),
    .MAX_FEATURES (MAX_FEATURES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .row_index     (row_index),
    .col_index     (col_index),
    .feature_index (feature_index),
    .data_value    (data_value),
    .last_flag     (last_flag),
    .cmd           (cmd),
    .status        (status),
    .scaled_value  (scaled_value),
    .last_out      (last_out)
  );

endmodule

`default_nettype wire
